// ----- rtl/vertex_constrained_strip_intersection_defines.svh -----
// Assertion macros shared by the strip intersection RTL.
`ifndef VERTEX_CONSTRAINED_STRIP_INTERSECTION_DEFINES_SVH
`define VERTEX_CONSTRAINED_STRIP_INTERSECTION_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define VCSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define VCSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vcsi_pkg.sv -----
// ----------------------------------------------------------------------------
// vcsi_pkg
// Shared widths and types of the strip intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vcsi_pkg;
    localparam int CoordWidth = 24;
    localparam int FracBits   = 24;
    localparam int DiffWidth  = CoordWidth + 2;            // vab, s, t
    localparam int CrossWidth = 2 * DiffWidth + 1;         // qs, rt
    localparam int DotWidth   = DiffWidth + CrossWidth + 2;
    localparam int QWidth     = FracBits + 2;              // quotient incl. rounding
    localparam int DivSteps   = FracBits + 1;
    localparam int FifoDepth  = 4;
    localparam int FifoAw     = $clog2(FifoDepth);

    localparam logic [1:0] RegVertexX = 2'd0;
    localparam logic [1:0] RegVertexY = 2'd1;
    localparam logic [1:0] RegVertexZ = 2'd2;

    typedef logic signed [CoordWidth-1:0] t_coord;
    typedef logic signed [DiffWidth-1:0]  t_diff;
    typedef logic signed [DotWidth-1:0]   t_dot;

    // Classified transaction handed from front to back.
    typedef struct packed {
        logic                 ok;
        logic                 neg;
        logic [DotWidth-1:0]  num_mag;
        logic [DotWidth-1:0]  den_mag;
        t_diff                sab_x;   // A+B
        t_diff                sab_y;
        t_diff                sab_z;
        t_diff                vab_x;
        t_diff                vab_y;
        t_diff                vab_z;
    } t_job;
endpackage

// ----- rtl/vcsi_front.sv -----
// ----------------------------------------------------------------------------
// vcsi_front
// Pipelined geometry: cross products, dot products and range classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcsi_front import vcsi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_coord i_vx, input t_coord i_vy, input t_coord i_vz,
    input  t_coord i_ax, input t_coord i_ay, input t_coord i_az,
    input  t_coord i_bx, input t_coord i_by, input t_coord i_bz,
    input  t_coord i_cx, input t_coord i_cy, input t_coord i_cz,
    input  t_coord i_dx, input t_coord i_dy, input t_coord i_dz,
    output logic   o_valid,
    output t_job   o_job
);
    typedef logic signed [CrossWidth-1:0] t_cr;
    typedef logic signed [2*DiffWidth-1:0] t_pr;
    localparam int Pw = DiffWidth + CrossWidth;
    localparam int Lo = CrossWidth / 2;
    localparam int Hw = DiffWidth + CrossWidth - Lo;
    typedef logic signed [Hw-1:0] t_hp;

    function automatic t_diff dif(input t_coord p, input t_coord q);
        dif = DiffWidth'(p) - DiffWidth'(q);
    endfunction
    function automatic t_diff smv(input t_coord p, input t_coord q, input t_coord v);
        smv = DiffWidth'(p) + DiffWidth'(q) - (DiffWidth'(v) <<< 1);
    endfunction
    // The wide cross term is split into a signed upper and an unsigned lower half.
    function automatic t_hp mhi(input t_diff a, input t_cr b);
        mhi = a * $signed(b[CrossWidth-1:Lo]);
    endfunction
    function automatic t_hp mlo(input t_diff a, input t_cr b);
        mlo = a * $signed({1'b0, b[Lo-1:0]});
    endfunction

    // stage 1: differences
    logic  [4:0] r_v;
    t_diff r_vab[3], r_vcd[3], r_s[3], r_t[3], r_sab[3];
    // stage 2: six products per cross
    t_pr   r_pq[6], r_pr[6];
    t_diff r2_vab[3], r2_vcd[3], r2_s[3], r2_t[3], r2_sab[3];
    // stage 3: cross products
    t_cr   r_qs[3], r_rt[3];
    t_diff r3_vab[3], r3_vcd[3], r3_s[3], r3_t[3], r3_sab[3];
    // stage 4: partial products of the dot product terms
    t_hp   r_hm[3], r_lm[3], r_hd[3], r_ld[3], r_hn[3], r_ln[3], r_he[3], r_le[3];
    t_diff r4_vab[3], r4_sab[3];
    // stage 5: dot product terms
    logic signed [Pw-1:0] r_tm[3], r_td[3], r_tn[3], r_te[3];
    t_diff r5_vab[3], r5_sab[3];

    t_dot w_nm, w_dm, w_nn, w_dn;
    logic [DotWidth-1:0] w_anm, w_adm, w_ann, w_adn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vab[0] <= dif(i_ax, i_bx); r_vab[1] <= dif(i_ay, i_by);
            r_vab[2] <= dif(i_az, i_bz);
            r_vcd[0] <= dif(i_cx, i_dx); r_vcd[1] <= dif(i_cy, i_dy);
            r_vcd[2] <= dif(i_cz, i_dz);
            r_s[0] <= smv(i_ax, i_bx, i_vx); r_s[1] <= smv(i_ay, i_by, i_vy);
            r_s[2] <= smv(i_az, i_bz, i_vz);
            r_t[0] <= smv(i_cx, i_dx, i_vx); r_t[1] <= smv(i_cy, i_dy, i_vy);
            r_t[2] <= smv(i_cz, i_dz, i_vz);
            r_sab[0] <= DiffWidth'(i_ax) + DiffWidth'(i_bx);
            r_sab[1] <= DiffWidth'(i_ay) + DiffWidth'(i_by);
            r_sab[2] <= DiffWidth'(i_az) + DiffWidth'(i_bz);

            // qs = vab x s, rt = vcd x t
            r_pq[0] <= r_vab[1] * r_s[2]; r_pq[1] <= r_vab[2] * r_s[1];
            r_pq[2] <= r_vab[2] * r_s[0]; r_pq[3] <= r_vab[0] * r_s[2];
            r_pq[4] <= r_vab[0] * r_s[1]; r_pq[5] <= r_vab[1] * r_s[0];
            r_pr[0] <= r_vcd[1] * r_t[2]; r_pr[1] <= r_vcd[2] * r_t[1];
            r_pr[2] <= r_vcd[2] * r_t[0]; r_pr[3] <= r_vcd[0] * r_t[2];
            r_pr[4] <= r_vcd[0] * r_t[1]; r_pr[5] <= r_vcd[1] * r_t[0];
            r2_vab <= r_vab; r2_vcd <= r_vcd; r2_s <= r_s; r2_t <= r_t;
            r2_sab <= r_sab;

            for (int i = 0; i < 3; i++) begin
                r_qs[i] <= CrossWidth'(r_pq[2*i]) - CrossWidth'(r_pq[2*i+1]);
                r_rt[i] <= CrossWidth'(r_pr[2*i]) - CrossWidth'(r_pr[2*i+1]);
            end
            r3_vab <= r2_vab; r3_vcd <= r2_vcd; r3_s <= r2_s; r3_t <= r2_t;
            r3_sab <= r2_sab;

            for (int i = 0; i < 3; i++) begin
                r_hm[i] <= mhi(r3_s[i], r_rt[i]);   r_lm[i] <= mlo(r3_s[i], r_rt[i]);
                r_hd[i] <= mhi(r3_vab[i], r_rt[i]); r_ld[i] <= mlo(r3_vab[i], r_rt[i]);
                r_hn[i] <= mhi(r3_t[i], r_qs[i]);   r_ln[i] <= mlo(r3_t[i], r_qs[i]);
                r_he[i] <= mhi(r3_vcd[i], r_qs[i]); r_le[i] <= mlo(r3_vcd[i], r_qs[i]);
            end
            r4_vab <= r3_vab; r4_sab <= r3_sab;

            for (int i = 0; i < 3; i++) begin
                r_tm[i] <= (Pw'(r_hm[i]) <<< Lo) + Pw'(r_lm[i]);
                r_td[i] <= (Pw'(r_hd[i]) <<< Lo) + Pw'(r_ld[i]);
                r_tn[i] <= (Pw'(r_hn[i]) <<< Lo) + Pw'(r_ln[i]);
                r_te[i] <= (Pw'(r_he[i]) <<< Lo) + Pw'(r_le[i]);
            end
            r5_vab <= r4_vab; r5_sab <= r4_sab;
        end
    end

    always_comb begin
        w_nm = DotWidth'(r_tm[0]) + DotWidth'(r_tm[1]) + DotWidth'(r_tm[2]);
        w_dm = DotWidth'(r_td[0]) + DotWidth'(r_td[1]) + DotWidth'(r_td[2]);
        w_nn = DotWidth'(r_tn[0]) + DotWidth'(r_tn[1]) + DotWidth'(r_tn[2]);
        w_dn = DotWidth'(r_te[0]) + DotWidth'(r_te[1]) + DotWidth'(r_te[2]);
        w_anm = w_nm[DotWidth-1] ? -w_nm : w_nm;
        w_adm = w_dm[DotWidth-1] ? -w_dm : w_dm;
        w_ann = w_nn[DotWidth-1] ? -w_nn : w_nn;
        w_adn = w_dn[DotWidth-1] ? -w_dn : w_dn;
    end

    assign o_valid = r_v[4];
    always_comb begin
        o_job.ok = (w_dm != '0) && (w_dn != '0) && (w_adm >= w_anm) && (w_adn >= w_ann);
        // m = -num/den is negative when num and den share a sign
        o_job.neg     = (w_nm[DotWidth-1] == w_dm[DotWidth-1]) && (w_nm != '0);
        o_job.num_mag = w_anm;
        o_job.den_mag = w_adm;
        o_job.sab_x = r5_sab[0]; o_job.sab_y = r5_sab[1]; o_job.sab_z = r5_sab[2];
        o_job.vab_x = r5_vab[0]; o_job.vab_y = r5_vab[1]; o_job.vab_z = r5_vab[2];
    end
endmodule

// ----- rtl/vcsi_fifo.sv -----
// ----------------------------------------------------------------------------
// vcsi_fifo
// Short queue between the front and the back, with a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcsi_fifo import vcsi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_data,
    input  logic  i_pop,
    output logic  o_empty,
    output logic  [FifoAw:0] o_count,
    output t_job  o_data
);
    t_job r_mem[FifoDepth];
    logic [FifoAw-1:0] r_wp, r_rp;
    logic [FifoAw:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FifoAw+1)'(i_push) - (FifoAw+1)'(i_pop);
        end
    end
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
endmodule

// ----- rtl/vcsi_back.sv -----
// ----------------------------------------------------------------------------
// vcsi_back
// Pipelined restoring divider for the ratio and the point interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcsi_back import vcsi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_job   i_job,
    output logic   o_valid,
    output logic   o_res,
    output t_coord o_px,
    output t_coord o_py,
    output t_coord o_pz
);
    localparam int Rw = DotWidth + 1;
    localparam int Mw = QWidth + 1;
    localparam int Aw = DiffWidth + FracBits + 2;
    localparam int Nst = DivSteps + 3;

    // divider stages: one quotient bit per stage
    logic [DivSteps:0]           r_v;
    t_job                        r_j[DivSteps+1];
    logic [Rw-1:0]               r_r[DivSteps+1];
    logic [QWidth-1:0]           r_q[DivSteps+1];
    logic [Nst-1:DivSteps+1]     r_vt;
    logic signed [Mw-1:0]        r_m;
    t_job                        r_jm;
    logic signed [Aw-1:0]        r_p[3];
    logic                        r_ok;
    logic                        r_vo;
    logic                        r_ro;
    t_coord                      r_o[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vt <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[DivSteps-1:0], i_valid};
            r_vt <= {r_vt[Nst-2:DivSteps+1], r_v[DivSteps]};
            r_vo <= r_vt[Nst-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [Rw-1:0] rem;
        logic [Rw-1:0] den;
        if (i_en) begin
            den = {1'b0, i_job.den_mag};
            rem = {1'b0, i_job.num_mag};
            r_j[0] <= i_job;
            if (rem >= den) begin
                r_r[0] <= rem - den; r_q[0] <= QWidth'(1);
            end else begin
                r_r[0] <= rem; r_q[0] <= '0;
            end
            for (int k = 0; k < DivSteps; k++) begin
                den = {1'b0, r_j[k].den_mag};
                rem = {r_r[k][Rw-2:0], 1'b0};
                r_j[k+1] <= r_j[k];
                if (rem >= den) begin
                    r_r[k+1] <= rem - den;
                    r_q[k+1] <= {r_q[k][QWidth-2:0], 1'b1};
                end else begin
                    r_r[k+1] <= rem;
                    r_q[k+1] <= {r_q[k][QWidth-2:0], 1'b0};
                end
            end
            // last step gives the rounding bit; q = (q2 >> 1) + lsb
            r_m  <= r_j[DivSteps].neg
                ? -Mw'((r_q[DivSteps] >> 1) + QWidth'(r_q[DivSteps][0]))
                :  Mw'((r_q[DivSteps] >> 1) + QWidth'(r_q[DivSteps][0]));
            r_jm <= r_j[DivSteps];
            r_ok <= r_jm.ok;
            r_p[0] <= (Aw'(r_jm.sab_x) <<< FracBits) + Aw'(r_m) * Aw'(r_jm.vab_x)
                      + (Aw'(1) <<< FracBits);
            r_p[1] <= (Aw'(r_jm.sab_y) <<< FracBits) + Aw'(r_m) * Aw'(r_jm.vab_y)
                      + (Aw'(1) <<< FracBits);
            r_p[2] <= (Aw'(r_jm.sab_z) <<< FracBits) + Aw'(r_m) * Aw'(r_jm.vab_z)
                      + (Aw'(1) <<< FracBits);
            r_ro <= r_ok;
            for (int i = 0; i < 3; i++)
                r_o[i] <= r_ok ? r_p[i][FracBits+CoordWidth:FracBits+1] : '0;
        end
    end

    assign o_valid = r_vo;
    assign o_res   = r_ro;
    assign o_px    = r_o[0];
    assign o_py    = r_o[1];
    assign o_pz    = r_o[2];
endmodule

// ----- rtl/vertex_constrained_strip_intersection.sv -----
// Pipeline: 5 front stages, the queue register and 29 back stages lie between an input
// transaction being accepted and its result being presented.
// Throughput: one transaction per cycle; each pipeline halts while its consumer stalls.
// The back divider retires one quotient bit per stage, which sets its depth.
// Reset (synchronous, active low) clears valid flags, queue pointers and the vertex.
// ----------------------------------------------------------------------------
// vertex_constrained_strip_intersection
// Top level: vertex registers, front classifier, queue and back interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_constrained_strip_intersection_defines.svh"
module vertex_constrained_strip_intersection import vcsi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [CoordWidth-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_coord i_a_x, input t_coord i_a_y, input t_coord i_a_z,
    input  t_coord i_b_x, input t_coord i_b_y, input t_coord i_b_z,
    input  t_coord i_c_x, input t_coord i_c_y, input t_coord i_c_z,
    input  t_coord i_d_x, input t_coord i_d_y, input t_coord i_d_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output t_coord      o_point_x,
    output t_coord      o_point_y,
    output t_coord      o_point_z
);
    t_coord r_vx, r_vy, r_vz;
    logic   w_fv, w_fen, w_empty, w_pop, w_ben, w_push;
    logic   [FifoAw:0] w_cnt;
    t_job   w_job, w_qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0; r_vy <= '0; r_vz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegVertexX: r_vx <= i_cfg_data;
                RegVertexY: r_vy <= i_cfg_data;
                RegVertexZ: r_vz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front advances while the queue has room for what it carries.
    assign w_fen   = !w_fv || (w_cnt < (FifoAw+1)'(FifoDepth));
    assign o_stall = !w_fen;
    assign w_push  = w_fv && w_fen;

    vcsi_front u_front (
        .i_clk, .i_rst_n, .i_en(w_fen), .i_valid(i_valid),
        .i_vx(r_vx), .i_vy(r_vy), .i_vz(r_vz),
        .i_ax(i_a_x), .i_ay(i_a_y), .i_az(i_a_z),
        .i_bx(i_b_x), .i_by(i_b_y), .i_bz(i_b_z),
        .i_cx(i_c_x), .i_cy(i_c_y), .i_cz(i_c_z),
        .i_dx(i_d_x), .i_dy(i_d_y), .i_dz(i_d_z),
        .o_valid(w_fv), .o_job(w_job)
    );

    vcsi_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_job),
        .i_pop(w_pop), .o_empty(w_empty), .o_count(w_cnt), .o_data(w_qjob)
    );

    assign w_ben = !(o_valid && i_stall);
    assign w_pop = w_ben && !w_empty;

    vcsi_back u_back (
        .i_clk, .i_rst_n, .i_en(w_ben), .i_valid(w_pop), .i_job(w_qjob),
        .o_valid(o_valid), .o_res(o_valid_res),
        .o_px(o_point_x), .o_py(o_point_y), .o_pz(o_point_z)
    );

    `VCSI_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, w_cnt < (FifoAw+1)'(FifoDepth),
        "queue overflow")
    `VCSI_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_pop, w_cnt != '0, "queue underflow")
    `VCSI_ASSERT_IMP(a_zero_invalid, i_clk, i_rst_n, o_valid && !o_valid_res,
        o_point_x == '0 && o_point_y == '0 && o_point_z == '0, "invalid point not zero")
    `VCSI_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_point_x), "stalled result changed")
endmodule

// ----- sim/vcsi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsi_checker
// Watches the configuration port and both channels of the strip intersection
// block, predicts each space point and compares it with the block's output.
// ----------------------------------------------------------------------------
module vcsi_checker import vcsi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [CoordWidth-1:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  t_coord      i_a_x, input t_coord i_a_y, input t_coord i_a_z,
    input  t_coord      i_b_x, input t_coord i_b_y, input t_coord i_b_z,
    input  t_coord      i_c_x, input t_coord i_c_y, input t_coord i_c_z,
    input  t_coord      i_d_x, input t_coord i_d_y, input t_coord i_d_z,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_valid_res,
    input  t_coord      i_point_x,
    input  t_coord      i_point_y,
    input  t_coord      i_point_z,
    output int          o_errors,
    output int          o_pending,
    output int          o_points,
    output int          o_accepted
);
    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic   ok;
        t_coord px;
        t_coord py;
        t_coord pz;
    } t_space_point;

    t_space_point point_queue[$];
    t_coord       vtx[3];

    function automatic t_wide mag(t_wide x);
        return x < 0 ? -x : x;
    endfunction

    function automatic t_space_point crossing(t_coord a[3], t_coord b[3], t_coord c[3],
                                              t_coord d[3], t_coord v[3]);
        t_wide vab[3], vcd[3], s[3], t[3], qs[3], rt[3];
        t_wide numm, denm, numn, denn, q, mq, acc;
        t_space_point r;
        for (int i = 0; i < 3; i++) begin
            vab[i] = t_wide'(a[i]) - t_wide'(b[i]);
            vcd[i] = t_wide'(c[i]) - t_wide'(d[i]);
            s[i]   = t_wide'(a[i]) + t_wide'(b[i]) - 2 * t_wide'(v[i]);
            t[i]   = t_wide'(c[i]) + t_wide'(d[i]) - 2 * t_wide'(v[i]);
        end
        for (int i = 0; i < 3; i++) begin
            qs[i] = vab[(i+1)%3] * s[(i+2)%3] - vab[(i+2)%3] * s[(i+1)%3];
            rt[i] = vcd[(i+1)%3] * t[(i+2)%3] - vcd[(i+2)%3] * t[(i+1)%3];
        end
        numm = s[0] * rt[0] + s[1] * rt[1] + s[2] * rt[2];
        denm = vab[0] * rt[0] + vab[1] * rt[1] + vab[2] * rt[2];
        numn = t[0] * qs[0] + t[1] * qs[1] + t[2] * qs[2];
        denn = vcd[0] * qs[0] + vcd[1] * qs[1] + vcd[2] * qs[2];
        r = '{ok: 1'b0, px: '0, py: '0, pz: '0};
        if (denm != 0 && denn != 0 && mag(numm) <= mag(denm) && mag(numn) <= mag(denn)) begin
            // Magnitude of m rounded to nearest with ties away from zero; m = -num/den.
            q  = ((mag(numm) <<< (FracBits + 1)) + mag(denm)) / (2 * mag(denm));
            mq = ((numm < 0) == (denm < 0)) ? -q : q;
            r.ok = 1'b1;
            for (int i = 0; i < 3; i++) begin
                acc = ((t_wide'(a[i]) + t_wide'(b[i])) <<< FracBits) + mq * vab[i]
                      + (t_wide'(1) <<< FracBits);
                acc = acc >>> (FracBits + 1);
                if (i == 0) r.px = acc[CoordWidth-1:0];
                else if (i == 1) r.py = acc[CoordWidth-1:0];
                else r.pz = acc[CoordWidth-1:0];
            end
        end
        return r;
    endfunction

    assign o_pending = point_queue.size();

    always @(posedge i_clk) begin
        t_space_point exp_pt;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            vtx = '{default: '0};
            point_queue.delete();
            o_errors   <= 0;
            o_points   <= 0;
            o_accepted <= 0;
        end else begin
            // An input taken at this edge still sees the vertex from before it.
            if (i_valid && !i_in_stall) begin
                point_queue = {point_queue,
                               crossing('{i_a_x, i_a_y, i_a_z}, '{i_b_x, i_b_y, i_b_z},
                                        '{i_c_x, i_c_y, i_c_z}, '{i_d_x, i_d_y, i_d_z},
                                        vtx)};
                o_accepted <= o_accepted + 1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegVertexX: vtx[0] = i_cfg_data;
                    RegVertexY: vtx[1] = i_cfg_data;
                    RegVertexZ: vtx[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (point_queue.size() == 0) begin
                    $error("result transaction with no expected point");
                    bad++;
                end else begin
                    exp_pt = point_queue.pop_front();
                    if (i_valid_res !== exp_pt.ok) begin
                        $error("valid_res: expected %0d, got %0d", exp_pt.ok, i_valid_res);
                        bad++;
                    end
                    if (i_point_x !== exp_pt.px) begin
                        $error("point_x: expected %0d, got %0d", exp_pt.px, i_point_x);
                        bad++;
                    end
                    if (i_point_y !== exp_pt.py) begin
                        $error("point_y: expected %0d, got %0d", exp_pt.py, i_point_y);
                        bad++;
                    end
                    if (i_point_z !== exp_pt.pz) begin
                        $error("point_z: expected %0d, got %0d", exp_pt.pz, i_point_z);
                        bad++;
                    end
                    if (exp_pt.ok) o_points <= o_points + 1;
                end
            end
            o_errors <= o_errors + bad;
        end
    end
endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives strip pairs and vertex settings into the strip intersection block
// with random gaps and back-pressure; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import vcsi_pkg::*;

    localparam int DrainCycles = 40;
    localparam int IdleLimit   = 3000;

    logic i_clk, i_rst_n, i_cfg_we, i_valid, o_stall, o_valid, i_stall, o_valid_res;
    logic [1:0] i_cfg_index;
    logic [CoordWidth-1:0] i_cfg_data;
    t_coord i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z;
    t_coord i_c_x, i_c_y, i_c_z, i_d_x, i_d_y, i_d_z;
    t_coord o_point_x, o_point_y, o_point_z;
    int errors, pending, points, accepted;
    int idle_cycles;
    bit calm;
    int stall_left;
    int vx, vy, vz;

    vertex_constrained_strip_intersection i_dut (.*);

    vcsi_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall),
        .i_a_x, .i_a_y, .i_a_z, .i_b_x, .i_b_y, .i_b_z,
        .i_c_x, .i_c_y, .i_c_z, .i_d_x, .i_d_y, .i_d_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_valid_res(o_valid_res), .i_point_x(o_point_x), .i_point_y(o_point_y),
        .i_point_z(o_point_z),
        .o_errors(errors), .o_pending(pending), .o_points(points), .o_accepted(accepted)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_stall = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z} = '0;
        {i_c_x, i_c_y, i_c_z, i_d_x, i_d_y, i_d_z} = '0;
    end

    // Receiver back-pressure: a fresh stall length after each result transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid && !i_stall) stall_left = calm ? 0 : $urandom_range(0, 9);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send(t_coord p[12]);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z} <= {p[0], p[1], p[2], p[3], p[4], p[5]};
        {i_c_x, i_c_y, i_c_z, i_d_x, i_d_y, i_d_z} <= {p[6], p[7], p[8], p[9], p[10], p[11]};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_vertex(int x, int y, int z);
        drain();
        vx = x; vy = y; vz = z;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data  <= (i == RegVertexX) ? x[CoordWidth-1:0] :
                           (i == RegVertexY) ? y[CoordWidth-1:0] :
                           (i == RegVertexZ) ? z[CoordWidth-1:0] : CoordWidth'($urandom());
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Front strip through X = vertex + delta, back strip through Y = vertex + 2 delta,
    // so both strips lie on one line from the vertex; frac/8 places X along A-B.
    task automatic send_track(int frac, int umax);
        int v[3], dl, u, w, x, m, y;
        t_coord p[12];
        v = '{vx, vy, vz};
        for (int i = 0; i < 3; i++) begin
            dl = $urandom_range(0, 1 << 20);
            if (v[i] > 0) dl = -dl;
            else if (v[i] == 0 && $urandom_range(0, 1)) dl = -dl;
            u = $urandom_range(0, 2 * umax) - umax;
            w = $urandom_range(0, 2 * umax) - umax;
            x = v[i] + dl;
            y = v[i] + 2 * dl;
            m = x - (frac * u) / 8;
            p[i] = t_coord'(m + u); p[3+i] = t_coord'(m - u);
            p[6+i] = t_coord'(y + w); p[9+i] = t_coord'(y - w);
        end
        send(p);
    endtask

    task automatic send_random(bit extreme);
        t_coord p[12];
        for (int i = 0; i < 12; i++) begin
            if (extreme) p[i] = $urandom_range(0, 1) ? {1'b0, {(CoordWidth-1){1'b1}}}
                                                     : {1'b1, {(CoordWidth-1){1'b0}}};
            else p[i] = t_coord'($urandom());
        end
        send(p);
    endtask

    task automatic send_degenerate();
        t_coord p[12];
        for (int i = 0; i < 12; i++) p[i] = t_coord'($urandom_range(0, 4095));
        if ($urandom_range(0, 1)) begin
            p[3] = p[0]; p[4] = p[1]; p[5] = p[2];
        end else begin
            // Back strip parallel to the front one.
            for (int i = 0; i < 3; i++) p[9+i] = p[6+i] - (p[i] - p[3+i]);
        end
        send(p);
    endtask

    initial begin
        t_coord zero[12], maxv[12], minv[12];
        int kind;
        zero = '{default: '0};
        maxv = '{default: {1'b0, {(CoordWidth-1){1'b1}}}};
        minv = '{default: {1'b1, {(CoordWidth-1){1'b0}}}};
        calm = 1'b1;
        vx = 0; vy = 0; vz = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: field extremes, degenerate and parallel strips, ratios of +1 and -1.
        send(zero);
        send(maxv);
        send(minv);
        repeat (3) send_random(1'b1);
        repeat (3) send_degenerate();
        send_track(8, 1000);
        send_track(-8, 1000);
        send_track(0, 1000);
        send_track(12, 1000);
        send_track(-12, 1000);
        set_vertex(8388607, -8388608, 8388607);
        send_track(8, 1 << 16);
        send_track(-8, 1 << 16);
        send(maxv);
        send(minv);
        set_vertex(-8388608, 8388607, -8388608);
        send_track(8, 1 << 16);
        send_track(-8, 1 << 16);
        send(zero);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) set_vertex(0, 0, 0);
            else set_vertex($urandom_range(0, 1 << 21) - (1 << 20),
                            $urandom_range(0, 1 << 21) - (1 << 20),
                            $urandom_range(0, 1 << 21) - (1 << 20));
            for (int n = 0; n < 250; n++) begin
                calm = (n >= 100 && n < 140);
                if (n == 180) drain();
                kind = $urandom_range(0, 99);
                if (kind < 65) send_track($urandom_range(0, 16) - 8, $urandom_range(1, 1 << 17));
                else if (kind < 75) send_track($urandom_range(0, 1) ? 9 : -9, 1 << 12);
                else if (kind < 82) send_degenerate();
                else if (kind < 87) send_random(1'b1);
                else send_random(1'b0);
            end
        end
        calm = 1'b0;
        drain();
        $display("Sent %0d strip pairs under a series of vertex settings, extremes included;",
                 accepted);
        $display("%0d crossings came back as valid space points.", points);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
